FILE: rtl/core/hie_pkg.sv
// Package with the widths and constants of the image histogram entropy block.
package hie_pkg;

  localparam int PIXEL_BITS = 8;
  localparam int COUNT_BITS = 20;
  localparam int FRAC_BITS  = 16;

  localparam int NUM_BINS = 1 << PIXEL_BITS;
  // Counts reach 2^COUNT_BITS, so they take one bit more.
  localparam int CW       = COUNT_BITS + 1;
  localparam int E_W      = $clog2(CW);
  localparam int LOG_W    = E_W + FRAC_BITS;
  localparam int MUL_W    = (CW > LOG_W) ? CW : LOG_W;
  localparam int SUM_W    = 2 * MUL_W;
  localparam int IDX_W    = $clog2(FRAC_BITS);
  localparam int DCNT_W   = $clog2(SUM_W);

  localparam int ENT_W    = 20;
  localparam int TOT_W    = 21;

  localparam logic [CW-1:0]    COUNT_LIMIT = CW'(1) << COUNT_BITS;
  localparam logic [ENT_W-1:0] ENT_MAX     = '1;

  typedef logic [CW-1:0]  count_t;
  typedef logic [LOG_W-1:0] log_t;
  typedef logic [SUM_W-1:0] sum_t;

endpackage

FILE: rtl/core/hie_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module hie_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

FILE: rtl/core/image_histogram_entropy.sv
// Top level of the image histogram entropy block: histogram RAM, log2 sequencer, divider.
//
// Usage: gray pixels enter on the in_ channel (in_pixel, in_last_pixel) with valid/ready.
// Each word is counted into a 256-bin histogram held in a RAM; a pixel is accepted in
// S_IDLE, then its bin is read-modify-written in S_UPD while in_ready is low.
// The word with in_last_pixel set closes the frame and starts the entropy pass, during
// which in_ready is low. The pass walks every bin through the one RAM read port: an empty
// bin is only addressed and checked; a non-empty one is also normalized, squared once per
// fraction bit, multiplied by its count and summed, all on one shared 21x21 multiplier.
// Then log2 of the pixel count takes another such run; a bit-serial divider yields 42 bits.
// The result word (out_entropy_q16 in Q4.16, out_pixel_total, out_count_saturated) sits
// in an output register until out_ready takes it; a following frame's pixels are still
// accepted meanwhile, and only that frame's result waits for the register to free up.
// Pixels beyond 2^20 in one frame are dropped and flagged. Reset (rst_n low,
// synchronous) empties the histogram at once through per-bin valid bits, so no clearing
// pass is needed; the same happens after every result.
module image_histogram_entropy
  import hie_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [7:0]       in_pixel,
  input  logic             in_last_pixel,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [ENT_W-1:0] out_entropy_q16,
  output logic [TOT_W-1:0] out_pixel_total,
  output logic             out_count_saturated
);

  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_UPD       = 4'd1;
  localparam logic [3:0] S_SCAN_ADDR = 4'd2;
  localparam logic [3:0] S_SCAN_CHK  = 4'd3;
  localparam logic [3:0] S_NORM      = 4'd4;
  localparam logic [3:0] S_SQ        = 4'd5;
  localparam logic [3:0] S_MUL       = 4'd6;
  localparam logic [3:0] S_ACC       = 4'd7;
  localparam logic [3:0] S_DIV       = 4'd8;
  localparam logic [3:0] S_OUT       = 4'd9;

  localparam logic [PIXEL_BITS-1:0] BIN_LAST = '1;
  localparam logic [E_W-1:0]        E_MAX    = E_W'(CW - 1);
  localparam logic [IDX_W-1:0]      I_LAST   = IDX_W'(FRAC_BITS - 1);
  localparam logic [DCNT_W-1:0]     D_LAST   = DCNT_W'(SUM_W - 1);

  logic [3:0]            state_r, state_nxt;
  logic [NUM_BINS-1:0]   vld_r, vld_nxt;
  count_t                frame_r, frame_nxt;
  logic                  ovf_r, ovf_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic                  tot_ph_r, tot_ph_nxt;

  logic [PIXEL_BITS-1:0] px_r, px_nxt;
  logic                  last_r, last_nxt;
  logic [PIXEL_BITS-1:0] bin_r, bin_nxt;
  count_t                x_r, x_nxt;
  count_t                t_r, t_nxt;
  logic [E_W-1:0]        e_r, e_nxt;
  logic [FRAC_BITS:0]    m_r, m_nxt;
  log_t                  res_r, res_nxt;
  logic [IDX_W-1:0]      i_r, i_nxt;
  sum_t                  prod_r, prod_nxt;
  sum_t                  sum_r, sum_nxt;
  sum_t                  q_r, q_nxt;
  count_t                rem_r, rem_nxt;
  logic [DCNT_W-1:0]     dcnt_r, dcnt_nxt;

  logic [ENT_W-1:0]      ent_r;
  logic [TOT_W-1:0]      tot_r;
  logic                  sat_r;

  logic                  wr_en;
  count_t                rd_data;
  logic [PIXEL_BITS-1:0] rd_addr;
  logic [PIXEL_BITS-1:0] cnt_idx;
  count_t                cnt_cur;
  logic [MUL_W-1:0]      mul_a, mul_b;
  sum_t                  prod;
  logic [FRAC_BITS+1:0]  sq;
  logic [CW:0]           remsh;
  logic                  qbit;
  logic                  scan_done;
  logic                  load;

  assign rd_addr = (state_r == S_IDLE) ? in_pixel[PIXEL_BITS-1:0] : bin_r;

  hie_ram #(
    .WIDTH(CW),
    .DEPTH(NUM_BINS)
  ) u_hist (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (px_r),
    .wr_data (cnt_cur + CW'(1)),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // The one shared multiplier: squaring steps of log2 and the count-times-log products.
  assign prod  = mul_a * mul_b;
  assign sq    = prod[FRAC_BITS +: FRAC_BITS+2];
  assign remsh = {rem_r, q_r[SUM_W-1]};

  always_comb begin
    state_nxt     = state_r;
    vld_nxt       = vld_r;
    frame_nxt     = frame_r;
    ovf_nxt       = ovf_r;
    tot_ph_nxt    = tot_ph_r;
    px_nxt        = px_r;
    last_nxt      = last_r;
    bin_nxt       = bin_r;
    x_nxt         = x_r;
    t_nxt         = t_r;
    e_nxt         = e_r;
    m_nxt         = m_r;
    res_nxt       = res_r;
    i_nxt         = i_r;
    prod_nxt      = prod_r;
    sum_nxt       = sum_r;
    q_nxt         = q_r;
    rem_nxt       = rem_r;
    dcnt_nxt      = dcnt_r;
    wr_en         = 1'b0;
    mul_a         = '0;
    mul_b         = '0;
    qbit          = 1'b0;
    scan_done     = 1'b0;
    load          = 1'b0;
    cnt_idx       = (state_r == S_UPD) ? px_r : bin_r;
    // A bin that was not written since the last clear reads as zero.
    cnt_cur       = vld_r[cnt_idx] ? rd_data : '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          px_nxt    = in_pixel[PIXEL_BITS-1:0];
          last_nxt  = in_last_pixel;
          state_nxt = S_UPD;
        end
      end
      S_UPD: begin
        if (frame_r < COUNT_LIMIT) begin
          wr_en          = 1'b1;
          vld_nxt[px_r]  = 1'b1;
          frame_nxt      = frame_r + CW'(1);
        end else begin
          ovf_nxt = 1'b1;
        end
        if (last_r) begin
          bin_nxt    = '0;
          sum_nxt    = '0;
          tot_ph_nxt = 1'b0;
          state_nxt  = S_SCAN_ADDR;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_SCAN_ADDR: state_nxt = S_SCAN_CHK;
      S_SCAN_CHK: begin
        if (cnt_cur != '0) begin
          x_nxt     = cnt_cur;
          t_nxt     = cnt_cur;
          e_nxt     = E_MAX;
          state_nxt = S_NORM;
        end else if (bin_r == BIN_LAST) begin
          scan_done = 1'b1;
        end else begin
          bin_nxt   = bin_r + PIXEL_BITS'(1);
          state_nxt = S_SCAN_ADDR;
        end
      end
      S_NORM: begin
        // One position a cycle until the leading one reaches the top bit.
        if (t_r[CW-1]) begin
          m_nxt     = t_r[CW-1 -: FRAC_BITS+1];
          res_nxt   = {e_r, {FRAC_BITS{1'b0}}};
          i_nxt     = '0;
          state_nxt = S_SQ;
        end else begin
          t_nxt = t_r << 1;
          e_nxt = e_r - E_W'(1);
        end
      end
      S_SQ: begin
        mul_a = MUL_W'(m_r);
        mul_b = MUL_W'(m_r);
        if (sq[FRAC_BITS+1]) begin
          m_nxt   = sq[FRAC_BITS+1:1];
          res_nxt = res_r | (LOG_W'(1) << (I_LAST - i_r));
        end else begin
          m_nxt = sq[FRAC_BITS:0];
        end
        i_nxt = i_r + IDX_W'(1);
        if (i_r == I_LAST) begin
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        mul_a     = MUL_W'(x_r);
        mul_b     = MUL_W'(res_r);
        prod_nxt  = prod;
        state_nxt = S_ACC;
      end
      S_ACC: begin
        if (tot_ph_r) begin
          q_nxt     = (prod_r > sum_r) ? prod_r - sum_r : '0;
          rem_nxt   = '0;
          dcnt_nxt  = '0;
          state_nxt = S_DIV;
        end else begin
          sum_nxt = sum_r + prod_r;
          if (bin_r == BIN_LAST) begin
            scan_done = 1'b1;
          end else begin
            bin_nxt   = bin_r + PIXEL_BITS'(1);
            state_nxt = S_SCAN_ADDR;
          end
        end
      end
      S_DIV: begin
        // Restoring division by the pixel count, one quotient bit a cycle.
        if (remsh >= {1'b0, frame_r}) begin
          rem_nxt = CW'(remsh - {1'b0, frame_r});
          qbit    = 1'b1;
        end else begin
          rem_nxt = remsh[CW-1:0];
        end
        q_nxt    = {q_r[SUM_W-2:0], qbit};
        dcnt_nxt = dcnt_r + DCNT_W'(1);
        if (dcnt_r == D_LAST) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          load      = 1'b1;
          vld_nxt   = '0;
          frame_nxt = '0;
          ovf_nxt   = 1'b0;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    // After the last bin, take log2 of the pixel count the same way, or output zero if none was counted.
    if (scan_done) begin
      if (frame_r == '0) begin
        q_nxt     = '0;
        state_nxt = S_OUT;
      end else begin
        x_nxt      = frame_r;
        t_nxt      = frame_r;
        e_nxt      = E_MAX;
        tot_ph_nxt = 1'b1;
        state_nxt  = S_NORM;
      end
    end

    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      vld_r       <= '0;
      frame_r     <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
      tot_ph_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      vld_r       <= vld_nxt;
      frame_r     <= frame_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
      tot_ph_r    <= tot_ph_nxt;
    end
  end

  always_ff @(posedge clk) begin
    px_r   <= px_nxt;
    last_r <= last_nxt;
    bin_r  <= bin_nxt;
    x_r    <= x_nxt;
    t_r    <= t_nxt;
    e_r    <= e_nxt;
    m_r    <= m_nxt;
    res_r  <= res_nxt;
    i_r    <= i_nxt;
    prod_r <= prod_nxt;
    sum_r  <= sum_nxt;
    q_r    <= q_nxt;
    rem_r  <= rem_nxt;
    dcnt_r <= dcnt_nxt;
    if (load) begin
      ent_r <= (q_r > SUM_W'(ENT_MAX)) ? ENT_MAX : q_r[ENT_W-1:0];
      tot_r <= TOT_W'(frame_r);
      sat_r <= ovf_r;
    end
  end

  assign in_ready            = (state_r == S_IDLE);
  assign out_valid           = out_valid_r;
  assign out_entropy_q16     = ent_r;
  assign out_pixel_total     = tot_r;
  assign out_count_saturated = sat_r;

  a_frame_limit: assert property (@(posedge clk) disable iff (!rst_n)
    frame_r <= COUNT_LIMIT)
    else $error("pixel count passed the count limit");

  a_norm_mant: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SQ) |-> m_r[FRAC_BITS])
    else $error("log2 mantissa not normalized during squaring");

  a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (rem_r < frame_r))
    else $error("divider remainder not below the divisor");

  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT && (!out_valid_r || out_ready)) |=>
      (frame_r == '0 && !ovf_r && vld_r == '0 && out_valid_r))
    else $error("frame state not cleared when the result word was loaded");

endmodule

FILE: tb/testbench.sv
// Testbench for image_histogram_entropy: directed frames, then random frames checked against a predictor.
module testbench
  import hie_pkg::*;
();

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_ready;
  logic [7:0]       in_pixel;
  logic             in_last_pixel;
  logic             out_valid;
  logic             out_ready;
  logic [ENT_W-1:0] out_entropy_q16;
  logic [TOT_W-1:0] out_pixel_total;
  logic             out_count_saturated;

  image_histogram_entropy uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_pixel(in_pixel), .in_last_pixel(in_last_pixel),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_entropy_q16(out_entropy_q16), .out_pixel_total(out_pixel_total),
    .out_count_saturated(out_count_saturated)
  );

  localparam int WATCHDOG_LIMIT = 200000;
  localparam int HOLD_CYCLES    = 20000;
  localparam int RANDOM_ITEMS   = 750;

  typedef struct {
    logic [ENT_W-1:0] entropy;
    logic [TOT_W-1:0] total;
    logic             saturated;
  } frame_result_t;

  typedef struct {
    logic [7:0]       pixel;
    logic             last;
    int unsigned      reps;
    logic [7:0]       step;
    bit               typed;
    logic [ENT_W-1:0] entropy;
    logic [TOT_W-1:0] total;
    logic             saturated;
  } stim_row_t;

  frame_result_t pending_results[$];
  count_t        hist[NUM_BINS];
  count_t        frame_count;
  logic          frame_dropped;

  int  errors = 0;
  int  frames_checked = 0;
  int  pixels_sent = 0;
  int  idle_cycles = 0;
  bit  tx_gaps = 1;
  bit  rx_gaps = 1;
  bit  hold_req = 0;
  bit  hold_done = 0;

  always #2 clk = ~clk;

  // Fixed-point log2: integer part from the leading one, then one fraction bit per squaring.
  function automatic longint unsigned log2_q(longint unsigned x);
    int e;
    longint unsigned m;
    longint unsigned r;
    if (x == 0) return 0;
    e = 0;
    while (e < 63 && (x >> (e + 1)) != 0) e++;
    if (e >= FRAC_BITS) m = x >> (e - FRAC_BITS);
    else m = x << (FRAC_BITS - e);
    r = longint'(e) << FRAC_BITS;
    for (int i = 0; i < FRAC_BITS; i++) begin
      m = (m * m) >> FRAC_BITS;
      if (m >= (64'd2 << FRAC_BITS)) begin
        m = m >> 1;
        r = r | (64'd1 << (FRAC_BITS - 1 - i));
      end
    end
    return r;
  endfunction

  function automatic void clear_histogram();
    foreach (hist[b]) hist[b] = '0;
    frame_count = '0;
    frame_dropped = 1'b0;
  endfunction

  // Counts one pixel; returns 1 and the frame's entropy when the pixel closes a frame.
  function automatic bit count_pixel(logic [7:0] px, logic last, output frame_result_t res);
    longint unsigned wsum;
    longint unsigned n;
    longint unsigned tot;
    longint unsigned ent;
    if (frame_count < COUNT_LIMIT) begin
      hist[px] = hist[px] + 1'b1;
      frame_count = frame_count + 1'b1;
    end else begin
      frame_dropped = 1'b1;
    end
    if (!last) return 0;
    wsum = 0;
    foreach (hist[b])
      if (hist[b] != 0) wsum += longint'(hist[b]) * log2_q(longint'(hist[b]));
    n = longint'(frame_count);
    if (n == 0) begin
      ent = 0;
    end else begin
      tot = n * log2_q(n);
      ent = (tot > wsum) ? (tot - wsum) / n : 0;
    end
    if (ent > longint'(ENT_MAX)) ent = longint'(ENT_MAX);
    res.entropy = ent[ENT_W-1:0];
    res.total = n[TOT_W-1:0];
    res.saturated = frame_dropped;
    clear_histogram();
    return 1;
  endfunction

  // Offers one word and waits for its acceptance; the predictor runs on acceptance.
  task automatic send_pixel(logic [7:0] px, logic last, bit typed, frame_result_t typed_res);
    frame_result_t res;
    while (tx_gaps && $urandom_range(99) < 6) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_pixel <= px;
    in_last_pixel <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pixels_sent++;
    if (count_pixel(px, last, res)) pending_results.push_back(typed ? typed_res : res);
  endtask

  stim_row_t directed[] = '{
    // A single pixel frame has no uncertainty.
    '{8'h00, 1'b1, 1, 8'd0, 1'b1, 20'd0, 21'd1, 1'b0},
    // Two different pixels give exactly one bit.
    '{8'hFF, 1'b0, 1, 8'd0, 1'b0, 20'd0, 21'd0, 1'b0},
    '{8'h00, 1'b1, 1, 8'd0, 1'b1, 20'd65536, 21'd2, 1'b0},
    // Every gray level once gives eight bits, the largest entropy.
    '{8'h00, 1'b0, 255, 8'd1, 1'b0, 20'd0, 21'd0, 1'b0},
    '{8'hFF, 1'b1, 1, 8'd0, 1'b1, 20'd524288, 21'd256, 1'b0},
    '{8'h55, 1'b0, 1, 8'd0, 1'b0, 20'd0, 21'd0, 1'b0},
    '{8'hAA, 1'b0, 2, 8'd0, 1'b0, 20'd0, 21'd0, 1'b0},
    '{8'hFF, 1'b1, 1, 8'd0, 1'b0, 20'd0, 21'd0, 1'b0},
    '{8'h12, 1'b0, 7, 8'd37, 1'b0, 20'd0, 21'd0, 1'b0},
    '{8'h12, 1'b1, 1, 8'd0, 1'b0, 20'd0, 21'd0, 1'b0},
    // A lone pixel after a busy frame starts from a clean histogram.
    '{8'h01, 1'b1, 1, 8'd0, 1'b1, 20'd0, 21'd1, 1'b0}
  };

  // Result checker.
  always @(posedge clk) begin
    frame_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result entropy %0d total %0d saturated %0d", $time,
                 out_entropy_q16, out_pixel_total, out_count_saturated);
        errors++;
      end else begin
        want = pending_results.pop_front();
        frames_checked++;
        if (out_entropy_q16 !== want.entropy) begin
          $display("%0t: entropy expected %0d actual %0d", $time, want.entropy,
                   out_entropy_q16);
          errors++;
        end
        if (out_pixel_total !== want.total) begin
          $display("%0t: pixel total expected %0d actual %0d", $time, want.total,
                   out_pixel_total);
          errors++;
        end
        if (out_count_saturated !== want.saturated) begin
          $display("%0t: saturated expected %0d actual %0d", $time, want.saturated,
                   out_count_saturated);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("testbench: done, errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Receiver: random stalls, plus one long hold-off so the next frame backs up.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1;
      end else begin
        out_ready <= !(rx_gaps && $urandom_range(99) < 6);
      end
    end
  end

  initial begin
    frame_result_t typed_res;
    frame_result_t none;
    int frame_len;
    int mode;
    logic [7:0] base;
    logic [7:0] px;
    int sent;
    clk = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_pixel = '0;
    in_last_pixel = 1'b0;
    none = '{default: '0};
    clear_histogram();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[r]) begin
      typed_res.entropy = directed[r].entropy;
      typed_res.total = directed[r].total;
      typed_res.saturated = directed[r].saturated;
      for (int unsigned i = 0; i < directed[r].reps; i++)
        send_pixel(directed[r].pixel + 8'(i) * directed[r].step, directed[r].last,
                   directed[r].typed, typed_res);
    end

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      frame_len = ($urandom_range(9) == 0) ? 1 : $urandom_range(2, 24);
      mode = $urandom_range(2);
      base = 8'($urandom);
      tx_gaps = !(sent >= 300 && sent < 550);
      rx_gaps = tx_gaps;
      if (sent >= 650 && !hold_req) hold_req = 1;
      for (int i = 0; i < frame_len; i++) begin
        case (mode)
          0: px = 8'($urandom);
          1: px = base + 8'($urandom_range(3));
          default: px = ($urandom_range(1)) ? base : 8'($urandom);
        endcase
        send_pixel(px, i == frame_len - 1, 1'b0, none);
        sent++;
      end
    end
    in_valid <= 1'b0;
    tx_gaps = 1;
    rx_gaps = 1;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("Sent %0d pixels and checked %0d frames, from one pixel up to every gray level.",
             pixels_sent, frames_checked);
    $display("Random frames mixed wide and narrow gray ranges under stalls on both sides.");
    if (errors == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/hie_pkg.sv
rtl/core/hie_ram.sv
rtl/core/image_histogram_entropy.sv
tb/testbench.sv
